/* rtl/axis_angle_vector_rotation_macros.svh */
// Assertion macros for the axis-angle vector rotation checker.
// No dependencies.
`ifndef AXIS_ANGLE_VECTOR_ROTATION_MACROS_SVH
`define AXIS_ANGLE_VECTOR_ROTATION_MACROS_SVH

// Check cons in the same cycle as ante.
`define AAVR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define AAVR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/aavr_pkg.sv */
// Shared constants, CORDIC angle table and queue entry type for the rotation block.
// No dependencies.
`timescale 1ns / 1ps

package aavr_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int TRIG_STEPS   = 16;
   localparam int ATAN_LEN     = 24;
   localparam int CORDIC_STEPS = (TRIG_STEPS > ATAN_LEN) ? ATAN_LEN : TRIG_STEPS;
   localparam int ANGLE_W      = 19;
   localparam int ANGLE_SHIFT  = 30 - FRAC_BITS;
   localparam int RED_W        = ANGLE_W + ANGLE_SHIFT + 2;
   localparam int CW           = 34;
   localparam int SQRT_STEPS   = 32;
   localparam int DIV_STEPS    = 31;
   localparam int NORM_STAGES  = SQRT_STEPS + DIV_STEPS;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

   localparam logic signed [63:0] Q30_ONE     = 64'sd1073741824;
   localparam logic signed [63:0] Q30_PI      = 64'sd3373259426;
   localparam logic signed [63:0] Q30_HALF_PI = 64'sd1686629713;
   localparam logic signed [63:0] Q30_TWO_PI  = 64'sd6746518852;
   localparam logic signed [63:0] CORDIC_GAIN = 64'sd652032874;
   localparam logic signed [63:0] ROUND_HALF  = 64'sd536870912;
   localparam logic signed [63:0] S32_MAX     = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN     = -64'sd2147483648;

   typedef struct packed {
      logic [2:0][31:0]     vec;
      logic [2:0][31:0]     amag;
      logic [2:0]           asgn;
      logic [63:0]          l2;
      logic signed [CW-1:0] ang;
      logic                 negate;
      logic                 zero;
   } front_type;

   function automatic logic signed [CW-1:0] atan_q30(input int idx);
      logic signed [CW-1:0] v;
      unique case (idx)
         0:  v = CW'(843314856);
         1:  v = CW'(497837829);
         2:  v = CW'(263043836);
         3:  v = CW'(133525158);
         4:  v = CW'(67021686);
         5:  v = CW'(33543515);
         6:  v = CW'(16775850);
         7:  v = CW'(8388437);
         8:  v = CW'(4194282);
         9:  v = CW'(2097149);
         10: v = CW'(1048575);
         11: v = CW'(524287);
         12: v = CW'(262143);
         13: v = CW'(131071);
         14: v = CW'(65535);
         15: v = CW'(32767);
         16: v = CW'(16383);
         17: v = CW'(8191);
         18: v = CW'(4095);
         19: v = CW'(2047);
         20: v = CW'(1023);
         21: v = CW'(511);
         22: v = CW'(255);
         23: v = CW'(127);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

/* rtl/axis_angle_vector_rotation.sv */
// Rotates a signed Q16.16 vector about an arbitrary axis by an angle in radians
// (Rodrigues form), with a queue interface on both sides. One request is taken
// per clock cycle when neither side stalls; the delay from an accepted request
// to its result is set mostly by the 32-step square root and the 31-step axis
// division pipelines in the back part, with the CORDIC running alongside. A zero
// axis returns the vector as is with rsp_axis_zero set; rsp_clipped marks a
// saturated component.
// Depends on aavr_pkg, aavr_front, aavr_fifo and aavr_back.
`timescale 1ns / 1ps

module axis_angle_vector_rotation (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [31:0]                  req_vec_x,
   input  logic signed [31:0]                  req_vec_y,
   input  logic signed [31:0]                  req_vec_z,
   input  logic signed [31:0]                  req_axis_x,
   input  logic signed [31:0]                  req_axis_y,
   input  logic signed [31:0]                  req_axis_z,
   input  logic signed [aavr_pkg::ANGLE_W-1:0] req_turn_angle,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [31:0]                  rsp_out_x,
   output logic signed [31:0]                  rsp_out_y,
   output logic signed [31:0]                  rsp_out_z,
   output logic                                rsp_axis_zero,
   output logic                                rsp_clipped
);

   logic                q_push;
   logic                q_full;
   logic                q_pop;
   logic                q_empty;
   aavr_pkg::front_type q_wdata;
   aavr_pkg::front_type q_rdata;

   aavr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .vec_x      (req_vec_x),
      .vec_y      (req_vec_y),
      .vec_z      (req_vec_z),
      .axis_x     (req_axis_x),
      .axis_y     (req_axis_y),
      .axis_z     (req_axis_z),
      .turn_angle (req_turn_angle),
      .q_push     (q_push),
      .q_data     (q_wdata),
      .q_full     (q_full)
   );

   aavr_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wdata),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (q_rdata),
      .empty   (q_empty)
   );

   aavr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (!q_empty),
      .q_data    (q_rdata),
      .q_pop     (q_pop),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .out_x     (rsp_out_x),
      .out_y     (rsp_out_y),
      .out_z     (rsp_out_z),
      .axis_zero (rsp_axis_zero),
      .clipped   (rsp_clipped)
   );

endmodule

/* rtl/aavr_front.sv */
// Front part: accepts requests, squares the axis, reduces the angle, flags a zero axis.
// Depends on aavr_pkg.
`timescale 1ns / 1ps

module aavr_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic signed [31:0]                    vec_x,
   input  logic signed [31:0]                    vec_y,
   input  logic signed [31:0]                    vec_z,
   input  logic signed [31:0]                    axis_x,
   input  logic signed [31:0]                    axis_y,
   input  logic signed [31:0]                    axis_z,
   input  logic signed [aavr_pkg::ANGLE_W-1:0]   turn_angle,
   output logic                                  q_push,
   output aavr_pkg::front_type                   q_data,
   input  logic                                  q_full
);

   localparam int RW = aavr_pkg::RED_W;
   localparam logic signed [RW-1:0] PI_R     = RW'(aavr_pkg::Q30_PI);
   localparam logic signed [RW-1:0] HALF_R   = RW'(aavr_pkg::Q30_HALF_PI);
   localparam logic signed [RW-1:0] TWO_PI_R = RW'(aavr_pkg::Q30_TWO_PI);

   logic                   adv;
   logic [2:0][31:0]       vec_w;
   logic [2:0][31:0]       axis_w;
   logic signed [RW-1:0]   ang_ext;
   logic signed [RW-1:0]   ang_wrap;
   logic signed [RW-1:0]   ang_red;
   logic                   negate_w;
   logic [63:0]            l2_w;
   logic signed [63:0]     sq_in [3];
   logic signed [63:0]     sq_ff [3];
   aavr_pkg::front_type    f1_in;
   aavr_pkg::front_type    f1_ff;
   aavr_pkg::front_type    f2_in;
   aavr_pkg::front_type    f2_ff;
   logic                   f1_valid_ff;
   logic                   f2_valid_ff;

   assign adv    = !(f2_valid_ff && q_full);
   assign full   = !adv;
   assign q_push = f2_valid_ff && !q_full;
   assign q_data = f2_ff;

   always_comb begin
      vec_w  = {vec_z, vec_y, vec_x};
      axis_w = {axis_z, axis_y, axis_x};
      ang_ext = {{(RW - aavr_pkg::ANGLE_W){turn_angle[aavr_pkg::ANGLE_W-1]}}, turn_angle}
                <<< aavr_pkg::ANGLE_SHIFT;
      ang_wrap = ang_ext;
      if (ang_ext > PI_R) begin
         ang_wrap = ang_ext - TWO_PI_R;
      end else if (ang_ext < -PI_R) begin
         ang_wrap = ang_ext + TWO_PI_R;
      end
      ang_red  = ang_wrap;
      negate_w = 1'b0;
      if (ang_wrap > HALF_R) begin
         ang_red  = ang_wrap - PI_R;
         negate_w = 1'b1;
      end else if (ang_wrap < -HALF_R) begin
         ang_red  = ang_wrap + PI_R;
         negate_w = 1'b1;
      end
      f1_in        = '0;
      f1_in.vec    = vec_w;
      f1_in.ang    = aavr_pkg::CW'(ang_red);
      f1_in.negate = negate_w;
      for (int k = 0; k < 3; k++) begin
         f1_in.asgn[k] = axis_w[k][31];
         f1_in.amag[k] = axis_w[k][31] ? (32'd0 - axis_w[k]) : axis_w[k];
         sq_in[k]      = $signed(axis_w[k]) * $signed(axis_w[k]);
      end
   end

   always_comb begin
      l2_w       = 64'(sq_ff[0]) + 64'(sq_ff[1]) + 64'(sq_ff[2]);
      f2_in      = f1_ff;
      f2_in.l2   = l2_w;
      f2_in.zero = (l2_w == 64'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_valid_ff <= push;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_ff <= f1_in;
         f2_ff <= f2_in;
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= sq_in[k];
         end
      end
   end

endmodule

/* rtl/aavr_fifo.sv */
// Short request queue between the front and back parts.
// Depends on aavr_pkg.
`timescale 1ns / 1ps

module aavr_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  aavr_pkg::front_type   wr_data,
   output logic                  full,
   input  logic                  pop,
   output aavr_pkg::front_type   rd_data,
   output logic                  empty
);

   localparam int AW = aavr_pkg::QUEUE_AW;

   aavr_pkg::front_type mem_ff [aavr_pkg::QUEUE_DEPTH];
   logic [AW-1:0]       wr_ptr_ff;
   logic [AW-1:0]       rd_ptr_ff;
   logic [AW:0]         count_ff;

   assign full    = (count_ff == (AW+1)'(aavr_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* rtl/aavr_back.sv */
// Back part: square root, axis division and CORDIC pipeline, matrix build and apply.
// Depends on aavr_pkg.
`timescale 1ns / 1ps

module aavr_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  aavr_pkg::front_type   q_data,
   output logic                  q_pop,
   input  logic                  pop,
   output logic                  empty,
   output logic signed [31:0]    out_x,
   output logic signed [31:0]    out_y,
   output logic signed [31:0]    out_z,
   output logic                  axis_zero,
   output logic                  clipped
);

   localparam int CW = aavr_pkg::CW;
   localparam int NS = aavr_pkg::NORM_STAGES;

   typedef struct packed {
      logic [2:0][31:0]     vec;
      logic [2:0][31:0]     amag;
      logic [2:0]           asgn;
      logic                 zero;
      logic                 negate;
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
      logic signed [CW-1:0] cz;
      logic [63:0]          rad;
      logic [34:0]          srem;
      logic [31:0]          root;
      logic [2:0][31:0]     drem;
      logic [2:0][30:0]     quo;
   } norm_type;

   function automatic logic signed [31:0] clamp_unit(input logic signed [63:0] v);
      logic signed [31:0] r;
      priority if (v > aavr_pkg::Q30_ONE) begin
         r = 32'(aavr_pkg::Q30_ONE);
      end else if (v < -aavr_pkg::Q30_ONE) begin
         r = 32'(-aavr_pkg::Q30_ONE);
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

   logic                  adv;
   norm_type              head;
   norm_type              st_in [NS];
   norm_type              st_ff [NS];
   logic [NS-1:0]         nv_ff;
   logic [4:0]            pv_ff;

   // matrix and apply stages
   norm_type              nl;
   logic signed [CW-1:0]  cx_f;
   logic signed [CW-1:0]  cy_f;
   logic signed [31:0]    u [3];
   logic signed [63:0]    uu_in [6];
   logic signed [63:0]    uu_ff [6];
   logic signed [63:0]    su_in [3];
   logic signed [63:0]    su_ff [3];
   logic signed [CW:0]    t_in;
   logic signed [CW:0]    t_ff;
   logic signed [CW-1:0]  cx1_ff;
   logic signed [CW-1:0]  cx2_ff;
   logic [2:0][31:0]      vec1_ff;
   logic [2:0][31:0]      vec2_ff;
   logic [2:0][31:0]      vec3_ff;
   logic [2:0][31:0]      vec4_ff;
   logic [3:0]            zero_ff;
   logic signed [31:0]    uh [6];
   logic signed [63:0]    ut_in [6];
   logic signed [63:0]    ut_ff [6];
   logic signed [63:0]    sk_in [3];
   logic signed [63:0]    sk_ff [3];
   logic signed [63:0]    uts [6];
   logic signed [63:0]    cx_w;
   logic signed [31:0]    rm_in [3][3];
   logic signed [31:0]    rm_ff [3][3];
   logic signed [63:0]    pr_in [3][3];
   logic signed [63:0]    pr_ff [3][3];
   logic signed [63:0]    acc [3];
   logic signed [63:0]    rnd [3];
   logic signed [31:0]    res_in [3];
   logic [2:0]            clip_w;
   logic signed [31:0]    res_ff [3];
   logic                  zero_out_ff;
   logic                  clip_ff;

   assign adv       = !pv_ff[4] || pop;
   assign q_pop     = adv && q_valid;
   assign empty     = !pv_ff[4];
   assign out_x     = res_ff[0];
   assign out_y     = res_ff[1];
   assign out_z     = res_ff[2];
   assign axis_zero = zero_out_ff;
   assign clipped   = clip_ff;

   always_comb begin
      head        = '0;
      head.vec    = q_data.vec;
      head.amag   = q_data.amag;
      head.asgn   = q_data.asgn;
      head.zero   = q_data.zero;
      head.negate = q_data.negate;
      head.cx     = CW'(aavr_pkg::CORDIC_GAIN);
      head.cz     = q_data.ang;
      head.rad    = q_data.l2;
   end

   for (genvar s = 0; s < NS; s++) begin : g_norm
      norm_type prev;
      if (s == 0) begin : g_head
         assign prev = head;
      end else begin : g_chain
         assign prev = st_ff[s-1];
      end

      always_comb begin
         logic [34:0]          rem2;
         logic [34:0]          trial;
         logic                 ge;
         logic [32:0]          r;
         logic                 dge;
         logic signed [CW-1:0] dx;
         logic signed [CW-1:0] dy;
         st_in[s] = prev;
         if (s < aavr_pkg::SQRT_STEPS) begin
            rem2  = {prev.srem[32:0], prev.rad[63:62]};
            trial = {1'b0, prev.root, 2'b01};
            ge    = (rem2 >= trial);
            st_in[s].srem = ge ? (rem2 - trial) : rem2;
            st_in[s].root = {prev.root[30:0], ge};
            st_in[s].rad  = {prev.rad[61:0], 2'b00};
         end else begin
            for (int j = 0; j < 3; j++) begin
               if (s == aavr_pkg::SQRT_STEPS) begin
                  r = {1'b0, prev.amag[j]};
               end else begin
                  r = {prev.drem[j], 1'b0};
               end
               dge = (r >= {1'b0, prev.root});
               st_in[s].drem[j] = dge ? 32'(r - {1'b0, prev.root}) : r[31:0];
               st_in[s].quo[j]  = {prev.quo[j][29:0], dge};
            end
         end
         if (s < aavr_pkg::CORDIC_STEPS) begin
            dx = $signed(prev.cy) >>> s;
            dy = $signed(prev.cx) >>> s;
            if (!prev.cz[CW-1]) begin
               st_in[s].cx = prev.cx - dx;
               st_in[s].cy = prev.cy + dy;
               st_in[s].cz = prev.cz - aavr_pkg::atan_q30(s);
            end else begin
               st_in[s].cx = prev.cx + dx;
               st_in[s].cy = prev.cy - dy;
               st_in[s].cz = prev.cz + aavr_pkg::atan_q30(s);
            end
         end
      end
   end

   // unit axis, sine and cosine, first products
   always_comb begin
      nl   = st_ff[NS-1];
      cx_f = nl.negate ? -$signed(nl.cx) : $signed(nl.cx);
      cy_f = nl.negate ? -$signed(nl.cy) : $signed(nl.cy);
      t_in = (CW+1)'(aavr_pkg::Q30_ONE) - (CW+1)'(cx_f);
      for (int k = 0; k < 3; k++) begin
         u[k] = nl.asgn[k] ? -$signed({1'b0, nl.quo[k]}) : $signed({1'b0, nl.quo[k]});
         su_in[k] = cy_f * u[k];
      end
      uu_in[0] = u[0] * u[0];
      uu_in[1] = u[1] * u[1];
      uu_in[2] = u[2] * u[2];
      uu_in[3] = u[0] * u[1];
      uu_in[4] = u[0] * u[2];
      uu_in[5] = u[1] * u[2];
   end

   always_comb begin
      for (int j = 0; j < 6; j++) begin
         uh[j]    = 32'(uu_ff[j] >>> 30);
         ut_in[j] = uh[j] * t_ff;
      end
      for (int k = 0; k < 3; k++) begin
         sk_in[k] = su_ff[k] >>> 30;
      end
   end

   always_comb begin
      for (int j = 0; j < 6; j++) begin
         uts[j] = ut_ff[j] >>> 30;
      end
      cx_w        = 64'(cx2_ff);
      rm_in[0][0] = clamp_unit(cx_w + uts[0]);
      rm_in[1][1] = clamp_unit(cx_w + uts[1]);
      rm_in[2][2] = clamp_unit(cx_w + uts[2]);
      rm_in[0][1] = clamp_unit(uts[3] - sk_ff[2]);
      rm_in[1][0] = clamp_unit(uts[3] + sk_ff[2]);
      rm_in[0][2] = clamp_unit(uts[4] + sk_ff[1]);
      rm_in[2][0] = clamp_unit(uts[4] - sk_ff[1]);
      rm_in[1][2] = clamp_unit(uts[5] - sk_ff[0]);
      rm_in[2][1] = clamp_unit(uts[5] + sk_ff[0]);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pr_in[i][j] = rm_ff[i][j] * $signed(vec3_ff[j]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = pr_ff[i][0] + pr_ff[i][1] + pr_ff[i][2] + aavr_pkg::ROUND_HALF;
         rnd[i] = acc[i] >>> 30;
         clip_w[i] = 1'b0;
         priority if (zero_ff[3]) begin
            res_in[i] = $signed(vec4_ff[i]);
         end else if (rnd[i] > aavr_pkg::S32_MAX) begin
            res_in[i] = 32'(aavr_pkg::S32_MAX);
            clip_w[i] = 1'b1;
         end else if (rnd[i] < aavr_pkg::S32_MIN) begin
            res_in[i] = 32'(aavr_pkg::S32_MIN);
            clip_w[i] = 1'b1;
         end else begin
            res_in[i] = 32'(rnd[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff <= '0;
         pv_ff <= '0;
      end else if (adv) begin
         nv_ff <= {nv_ff[NS-2:0], q_valid};
         pv_ff <= {pv_ff[3:0], nv_ff[NS-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < NS; s++) begin
            st_ff[s] <= st_in[s];
         end
         uu_ff    <= uu_in;
         su_ff    <= su_in;
         t_ff     <= t_in;
         cx1_ff   <= cx_f;
         vec1_ff  <= nl.vec;
         ut_ff    <= ut_in;
         sk_ff    <= sk_in;
         cx2_ff   <= cx1_ff;
         vec2_ff  <= vec1_ff;
         rm_ff    <= rm_in;
         vec3_ff  <= vec2_ff;
         pr_ff    <= pr_in;
         vec4_ff  <= vec3_ff;
         zero_ff  <= {zero_ff[2:0], nl.zero};
         res_ff   <= res_in;
         zero_out_ff <= zero_ff[3];
         clip_ff  <= |clip_w;
      end
   end

endmodule

/* rtl/aavr_checker.sv */
// Port-level checks for the rotation block, bound to its top level.
// Depends on axis_angle_vector_rotation_macros.svh.
`timescale 1ns / 1ps
`include "axis_angle_vector_rotation_macros.svh"

module aavr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_full,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic signed [31:0] rsp_out_x,
   input logic signed [31:0] rsp_out_y,
   input logic signed [31:0] rsp_out_z,
   input logic               rsp_axis_zero,
   input logic               rsp_clipped
);

   `AAVR_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, rsp_empty && !req_full, "not idle after reset")

   `AAVR_ASSERT_NOW(a_zero_no_clip, clock, reset, !rsp_empty && rsp_axis_zero, !rsp_clipped, "zero axis request marked clipped")

   `AAVR_ASSERT_NOW(a_clip_at_rail, clock, reset, !rsp_empty && rsp_clipped, rsp_out_x == 32'h7fffffff || rsp_out_x == 32'h80000000 || rsp_out_y == 32'h7fffffff || rsp_out_y == 32'h80000000 || rsp_out_z == 32'h7fffffff || rsp_out_z == 32'h80000000, "clipped without a saturated component")

   `AAVR_ASSERT_NEXT(a_hold_result, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_out_z) && $stable(rsp_axis_zero) && $stable(rsp_clipped), "waiting result changed")

endmodule

bind axis_angle_vector_rotation aavr_checker u_checker (.*);
